// File: sv/sts_pkg.sv
// Shared types, constants and helper functions for the SQL token scanner.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package sts_pkg;

    localparam int OFFSET_BITS   = 16;
    localparam int KEYWORD_CHARS = 7;
    localparam int TOKEN_BITS    = 16;
    localparam int KIND_BITS     = 5;
    localparam int KW_COUNT      = 15;
    localparam int KW_MAX_LEN    = 7;
    localparam int WIN_IDX_BITS  = $clog2(KEYWORD_CHARS);

    typedef logic [OFFSET_BITS-1:0] offset_t;
    typedef logic [KEYWORD_CHARS-1:0][7:0] kw_window_t;
    typedef logic [KIND_BITS-1:0] kind_t;

    localparam offset_t OFFSET_MAX = {OFFSET_BITS{1'b1}};

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_LT,
        MODE_GT,
        MODE_BANG
    } scan_mode_t;

    localparam kind_t KIND_END    = 5'd0;
    localparam kind_t KIND_IDENT  = 5'd1;
    localparam kind_t KIND_NUMBER = 5'd2;
    localparam kind_t KIND_STRING = 5'd3;
    localparam kind_t KIND_KW0    = 5'd4;
    localparam kind_t KIND_STAR   = 5'd19;
    localparam kind_t KIND_COMMA  = 5'd20;
    localparam kind_t KIND_SEMI   = 5'd21;
    localparam kind_t KIND_LPAR   = 5'd22;
    localparam kind_t KIND_RPAR   = 5'd23;
    localparam kind_t KIND_EQ     = 5'd24;
    localparam kind_t KIND_LT     = 5'd25;
    localparam kind_t KIND_LTE    = 5'd26;
    localparam kind_t KIND_GT     = 5'd27;
    localparam kind_t KIND_GTE    = 5'd28;
    localparam kind_t KIND_NEQ    = 5'd29;

    localparam logic [7:0] CHAR_NUL    = 8'h00;
    localparam logic [7:0] CHAR_DQUOTE = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE = 8'h27;
    localparam logic [7:0] CHAR_UNDER  = 8'h5F;
    localparam logic [7:0] CHAR_LT     = 8'h3C;
    localparam logic [7:0] CHAR_GT     = 8'h3E;
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_LPAR   = 8'h28;
    localparam logic [7:0] CHAR_RPAR   = 8'h29;
    localparam logic [7:0] CHAR_EQ     = 8'h3D;

    // Keyword text is right-aligned: the last character sits in bits 7:0.
    localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
        64'("SELECT"), 64'("INSERT"), 64'("DELETE"), 64'("UPDATE"), 64'("CREATE"),
        64'("TABLE"), 64'("FROM"), 64'("WHERE"), 64'("VALUES"), 64'("VARCHAR"),
        64'("INTO"), 64'("SET"), 64'("AND"), 64'("OR"), 64'("INT")
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd5, 3'd4, 3'd5, 3'd6, 3'd7,
        3'd4, 3'd3, 3'd3, 3'd2, 3'd3
    };

    typedef struct packed {
        kind_t                 token_kind;
        logic [TOKEN_BITS-1:0] token_start;
        logic [TOKEN_BITS-1:0] token_length;
        logic                  string_closed;
        logic                  last_of_run;
    } token_t;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_space(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] to_upper(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic offset_t sat_inc(offset_t v);
        return (v == OFFSET_MAX) ? OFFSET_MAX : v + offset_t'(1);
    endfunction

endpackage

// File: sv/sts_channels.sv
// Valid/ready channel interfaces for the scanner: text bytes in, tokens out.
// Depends on sts_pkg.
`timescale 1ns / 1ps

interface sts_text_if import sts_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] char_byte;

    modport source (output valid, output action, output char_byte, input ready);
    modport sink (input valid, input action, input char_byte, output ready);
endinterface

interface sts_token_if import sts_pkg::*; ();
    logic                  valid;
    logic                  ready;
    kind_t                 token_kind;
    logic [TOKEN_BITS-1:0] token_start;
    logic [TOKEN_BITS-1:0] token_length;
    logic                  string_closed;
    logic                  last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output string_closed, output last_of_run,
                    input ready);
    modport sink (input valid, input token_kind, input token_start,
                  input token_length, input string_closed, input last_of_run,
                  output ready);
endinterface

// File: sv/sql_token_scanner.sv
// Top level of the SQL token scanner: byte scanner state and the token queue.
// Depends on sts_pkg and the channel interfaces in sts_channels.sv.
`timescale 1ns / 1ps

// The scanner takes one text item per clock cycle and updates its state in the
// same cycle; each item yields zero, one or two tokens, which go into a
// four-entry queue that drains one token per cycle on the token channel while
// its ready is high. Input ready is high whenever at least two queue entries
// are free, so text streams at one item per cycle as long as tokens are taken
// at least as fast as they are produced. No clearing pass follows reset.
module sql_token_scanner import sts_pkg::*; (
    input logic         clk,
    input logic         rst_n,
    sts_text_if.sink    text,
    sts_token_if.source tokens
);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    scan_mode_t mode_reg, mode_next;
    logic       quote_reg, quote_next;
    offset_t    pos_reg, pos_next;
    offset_t    start_reg, start_next;
    offset_t    len_reg, len_next;
    kw_window_t window_reg, window_next;

    token_t                queue_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0]  count_reg, count_next;

    token_t     slot0, slot1;
    logic [1:0] push_n;
    logic       accept;
    logic       pop;
    token_t     head;

    function automatic kind_t ident_kind(kw_window_t w, offset_t len);
        kind_t kind;
        logic  hit;
        kind = KIND_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            hit = (len == offset_t'(KW_LEN[k]));
            for (int i = 0; i < KW_MAX_LEN; i++) begin
                if (i < int'(KW_LEN[k]) &&
                    w[i] != KW_TEXT[k][8 * (int'(KW_LEN[k]) - 1 - i) +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                kind = KIND_KW0 + kind_t'(k);
            end
        end
        return kind;
    endfunction

    function automatic token_t make_token(kind_t kind, offset_t start, offset_t len,
                                          logic closed);
        token_t t;
        t.token_kind    = kind;
        t.token_start   = TOKEN_BITS'(start);
        t.token_length  = TOKEN_BITS'(len);
        t.string_closed = closed;
        t.last_of_run   = 1'b0;
        return t;
    endfunction

    assign accept = text.valid && text.ready;
    assign pop    = tokens.valid && tokens.ready;

    always_comb
    begin
        token_t     flush_tok, scan_tok, done_tok, end_tok;
        logic       flush_v, scan_v, done_v, cont;
        scan_mode_t idle_mode;
        logic       idle_quote;
        offset_t    idle_start, idle_len;
        kw_window_t idle_window;
        logic [7:0] c;
        logic       quote_hit;

        c = text.char_byte;

        mode_next   = mode_reg;
        quote_next  = quote_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        len_next    = len_reg;
        window_next = window_reg;
        slot0       = make_token(KIND_END, pos_reg, '0, 1'b0);
        slot1       = slot0;
        push_n      = 2'd0;

        flush_v = (mode_reg != MODE_IDLE);
        unique case (mode_reg)
            MODE_IDENT:  flush_tok = make_token(ident_kind(window_reg, len_reg),
                                                start_reg, len_reg, 1'b0);
            MODE_NUMBER: flush_tok = make_token(KIND_NUMBER, start_reg, len_reg, 1'b0);
            MODE_STRING: flush_tok = make_token(KIND_STRING, start_reg, len_reg, 1'b0);
            MODE_LT:     flush_tok = make_token(KIND_LT, start_reg, offset_t'(1), 1'b0);
            MODE_GT:     flush_tok = make_token(KIND_GT, start_reg, offset_t'(1), 1'b0);
            MODE_BANG:   flush_tok = make_token(KIND_IDENT, start_reg, offset_t'(1), 1'b0);
            default:     flush_tok = make_token(KIND_END, start_reg, '0, 1'b0);
        endcase

        // Scan of the byte from the idle state, at the current offset.
        idle_mode   = MODE_IDLE;
        idle_quote  = quote_reg;
        idle_start  = start_reg;
        idle_len    = len_reg;
        idle_window = window_reg;
        scan_v      = 1'b0;
        scan_tok    = make_token(KIND_IDENT, pos_reg, offset_t'(1), 1'b0);
        priority if (is_space(c))
        begin
            scan_v = 1'b0;
        end
        else if (is_alpha(c))
        begin
            idle_mode      = MODE_IDENT;
            idle_window    = '0;
            idle_window[0] = to_upper(c);
            idle_start     = pos_reg;
            idle_len       = offset_t'(1);
        end
        else if (is_digit(c))
        begin
            idle_mode  = MODE_NUMBER;
            idle_start = pos_reg;
            idle_len   = offset_t'(1);
        end
        else if (c == CHAR_SQUOTE || c == CHAR_DQUOTE)
        begin
            idle_mode  = MODE_STRING;
            idle_quote = (c == CHAR_DQUOTE);
            idle_start = sat_inc(pos_reg);
            idle_len   = '0;
        end
        else if (c == CHAR_LT || c == CHAR_GT || c == CHAR_BANG)
        begin
            idle_mode  = (c == CHAR_LT) ? MODE_LT : (c == CHAR_GT) ? MODE_GT : MODE_BANG;
            idle_start = pos_reg;
            idle_len   = offset_t'(1);
        end
        else
        begin
            scan_v = 1'b1;
            unique case (c)
                CHAR_STAR:  scan_tok.token_kind = KIND_STAR;
                CHAR_COMMA: scan_tok.token_kind = KIND_COMMA;
                CHAR_SEMI:  scan_tok.token_kind = KIND_SEMI;
                CHAR_LPAR:  scan_tok.token_kind = KIND_LPAR;
                CHAR_RPAR:  scan_tok.token_kind = KIND_RPAR;
                CHAR_EQ:    scan_tok.token_kind = KIND_EQ;
                default:    scan_tok.token_kind = KIND_IDENT;
            endcase
        end

        // Continuation of the pending token, or a token closed by this byte.
        cont      = 1'b0;
        done_v    = 1'b0;
        done_tok  = make_token(KIND_STRING, start_reg, len_reg, 1'b1);
        quote_hit = quote_reg ? (c == CHAR_DQUOTE) : (c == CHAR_SQUOTE);
        unique case (mode_reg)
            MODE_IDENT:
            begin
                cont = is_alpha(c) || is_digit(c) || c == CHAR_UNDER;
            end
            MODE_NUMBER:
            begin
                cont = is_digit(c);
            end
            MODE_STRING:
            begin
                done_v = quote_hit;
                cont   = !quote_hit && c != CHAR_NUL;
            end
            MODE_LT, MODE_GT, MODE_BANG:
            begin
                done_v   = (c == CHAR_EQ);
                done_tok = make_token((mode_reg == MODE_LT) ? KIND_LTE :
                                      (mode_reg == MODE_GT) ? KIND_GTE : KIND_NEQ,
                                      start_reg, offset_t'(2), 1'b0);
            end
            default:
            begin
                cont = 1'b0;
            end
        endcase

        end_tok = make_token(KIND_END, pos_reg, '0, 1'b0);

        if (accept)
        begin
            if (text.action)
            begin
                mode_next = MODE_IDLE;
                pos_next  = '0;
                if (flush_v)
                begin
                    slot0  = flush_tok;
                    slot1  = end_tok;
                    push_n = 2'd2;
                end
                else
                begin
                    slot0  = end_tok;
                    push_n = 2'd1;
                end
            end
            else
            begin
                pos_next = sat_inc(pos_reg);
                if (cont)
                begin
                    if (mode_reg == MODE_IDENT &&
                        len_reg < offset_t'(KEYWORD_CHARS))
                    begin
                        window_next[len_reg[WIN_IDX_BITS-1:0]] = to_upper(c);
                    end
                    len_next = sat_inc(len_reg);
                end
                else if (done_v)
                begin
                    mode_next = MODE_IDLE;
                    slot0     = done_tok;
                    push_n    = 2'd1;
                end
                else
                begin
                    mode_next   = idle_mode;
                    quote_next  = idle_quote;
                    start_next  = idle_start;
                    len_next    = idle_len;
                    window_next = idle_window;
                    if (flush_v)
                    begin
                        slot0  = flush_tok;
                        slot1  = scan_tok;
                        push_n = scan_v ? 2'd2 : 2'd1;
                    end
                    else
                    begin
                        slot0  = scan_tok;
                        push_n = scan_v ? 2'd1 : 2'd0;
                    end
                end
            end
        end

        slot0.last_of_run = (push_n == 2'd1);
        slot1.last_of_run = 1'b1;
    end

    assign wr_ptr_next = wr_ptr_reg + QPTR_BITS'(push_n);
    assign rd_ptr_next = rd_ptr_reg + QPTR_BITS'(pop);
    assign count_next  = count_reg + QCNT_BITS'(push_n) - QCNT_BITS'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            quote_reg  <= 1'b0;
            pos_reg    <= '0;
            start_reg  <= '0;
            len_reg    <= '0;
            window_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            mode_reg   <= mode_next;
            quote_reg  <= quote_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
            window_reg <= window_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= slot0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[wr_ptr_reg + QPTR_BITS'(1)] <= slot1;
        end
    end

    assign head       = queue_reg[rd_ptr_reg];
    assign text.ready = (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));

    assign tokens.valid         = (count_reg != '0);
    assign tokens.token_kind    = head.token_kind;
    assign tokens.token_start   = head.token_start;
    assign tokens.token_length  = head.token_length;
    assign tokens.string_closed = head.string_closed;
    assign tokens.last_of_run   = head.last_of_run;

endmodule

// File: sv/sts_checker.sv
// Port-level assertions for the SQL token scanner and the bind that attaches them.
// Depends on sts_pkg and sql_token_scanner.
`timescale 1ns / 1ps

module sts_checker import sts_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  out_valid,
    input logic                  out_ready,
    input kind_t                 token_kind,
    input logic [TOKEN_BITS-1:0] token_start,
    input logic [TOKEN_BITS-1:0] token_length,
    input logic                  string_closed,
    input logic                  last_of_run
);

    // A stalled token stays offered unchanged.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(token_kind) &&
            $stable(token_start) && $stable(token_length) &&
            $stable(string_closed) && $stable(last_of_run))
    else $error("stalled token changed");

    // Both tokens of one item are queued together, so the second follows at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=> out_valid)
    else $error("second token of an item not available");

    // End of statement is always the final token of its item and has no text.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == KIND_END |-> last_of_run && token_length == '0)
    else $error("malformed end token");

    // Only strings report a closing quote.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && string_closed |-> token_kind == KIND_STRING)
    else $error("closed flag on a non-string token");

endmodule

bind sql_token_scanner sts_checker u_sts_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (tokens.valid),
    .out_ready     (tokens.ready),
    .token_kind    (tokens.token_kind),
    .token_start   (tokens.token_start),
    .token_length  (tokens.token_length),
    .string_closed (tokens.string_closed),
    .last_of_run   (tokens.last_of_run)
);

// File: tb/tb_sql_token_scanner.sv
// Self-checking testbench for sql_token_scanner: random and directed SQL text, tokens
// predicted in the bench and compared in order. Depends on sts_pkg and sts_channels.sv.
`timescale 1ns / 1ps

module tb_sql_token_scanner;
    import sts_pkg::*;

    localparam int CYCLE_LIMIT = 60000;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_LINES = 100;

    typedef struct packed {
        logic       action;
        logic [7:0] char_byte;
    } text_item_t;

    logic clk;
    logic rst_n;

    sts_text_if  text_ch ();
    sts_token_if tok_ch ();

    sql_token_scanner dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .tokens (tok_ch)
    );

    text_item_t  text_queue [$];
    text_item_t  item_now;
    token_t      tokens_due [$];
    token_t      step_out [$];
    int          send_gap_pct = 36;
    int          recv_gap_pct = 82;
    int          items_pushed = 0;
    int          items_taken = 0;
    int          mismatches = 0;
    int unsigned cycles = 0;

    string kw_words [KW_COUNT] = '{"SELECT", "INSERT", "DELETE", "UPDATE", "CREATE",
        "TABLE", "FROM", "WHERE", "VALUES", "VARCHAR", "INTO", "SET", "AND", "OR", "INT"};
    string sym_words [12] = '{"*", ",", ";", "(", ")", "=", "<", "<=", ">", ">=", "!=", "!"};

    scan_mode_t mode;
    logic       dq_open;
    offset_t    scan_pos;
    offset_t    run_start;
    offset_t    run_len;
    kw_window_t window;

    function automatic offset_t sat_step(offset_t v);
        return (v == '1) ? v : v + offset_t'(1);
    endfunction

    function automatic logic letter(logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic logic digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic blank(logic [7:0] c);
        return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
    endfunction

    function automatic logic [7:0] upper(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    function automatic kind_t word_kind();
        logic hit;
        for (int i = 0; i < KW_COUNT; i++)
        begin
            if (run_len == offset_t'(kw_words[i].len()))
            begin
                hit = 1'b1;
                for (int j = 0; j < kw_words[i].len(); j++)
                begin
                    if (window[j] != kw_words[i][j])
                        hit = 1'b0;
                end
                if (hit)
                    return KIND_KW0 + kind_t'(i);
            end
        end
        return KIND_IDENT;
    endfunction

    task automatic note_token(kind_t k, offset_t s, offset_t n, logic closed);
        token_t t;
        t.token_kind = k;
        t.token_start = s;
        t.token_length = n;
        t.string_closed = closed;
        t.last_of_run = 1'b0;
        step_out.insert(step_out.size(), t);
    endtask

    task automatic open_run(scan_mode_t m, offset_t s, offset_t n);
        mode = m;
        run_start = s;
        run_len = n;
    endtask

    task automatic flush_run();
        case (mode)
            MODE_IDENT:  note_token(word_kind(), run_start, run_len, 1'b0);
            MODE_NUMBER: note_token(KIND_NUMBER, run_start, run_len, 1'b0);
            MODE_STRING: note_token(KIND_STRING, run_start, run_len, 1'b0);
            MODE_LT:     note_token(KIND_LT, run_start, offset_t'(1), 1'b0);
            MODE_GT:     note_token(KIND_GT, run_start, offset_t'(1), 1'b0);
            MODE_BANG:   note_token(KIND_IDENT, run_start, offset_t'(1), 1'b0);
            default:     ;
        endcase
        mode = MODE_IDLE;
    endtask

    task automatic start_fresh(logic [7:0] c, offset_t here);
        mode = MODE_IDLE;
        if (blank(c))
            return;
        if (letter(c))
        begin
            window = '0;
            window[0] = upper(c);
            open_run(MODE_IDENT, here, offset_t'(1));
        end
        else if (digit(c))
            open_run(MODE_NUMBER, here, offset_t'(1));
        else if (c == CHAR_SQUOTE || c == CHAR_DQUOTE)
        begin
            dq_open = (c == CHAR_DQUOTE);
            open_run(MODE_STRING, sat_step(here), '0);
        end
        else
        begin
            case (c)
                CHAR_LT:    open_run(MODE_LT, here, offset_t'(1));
                CHAR_GT:    open_run(MODE_GT, here, offset_t'(1));
                CHAR_BANG:  open_run(MODE_BANG, here, offset_t'(1));
                CHAR_STAR:  note_token(KIND_STAR, here, offset_t'(1), 1'b0);
                CHAR_COMMA: note_token(KIND_COMMA, here, offset_t'(1), 1'b0);
                CHAR_SEMI:  note_token(KIND_SEMI, here, offset_t'(1), 1'b0);
                CHAR_LPAR:  note_token(KIND_LPAR, here, offset_t'(1), 1'b0);
                CHAR_RPAR:  note_token(KIND_RPAR, here, offset_t'(1), 1'b0);
                CHAR_EQ:    note_token(KIND_EQ, here, offset_t'(1), 1'b0);
                default:    note_token(KIND_IDENT, here, offset_t'(1), 1'b0);
            endcase
        end
    endtask

    task automatic scan_item(logic act, logic [7:0] c);
        offset_t here;
        logic    taken;
        step_out.delete();
        if (act)
        begin
            flush_run();
            note_token(KIND_END, scan_pos, '0, 1'b0);
            scan_pos = '0;
            mode = MODE_IDLE;
        end
        else
        begin
            here = scan_pos;
            scan_pos = sat_step(scan_pos);
            taken = 1'b0;
            case (mode)
                MODE_IDENT:
                begin
                    if (letter(c) || digit(c) || c == CHAR_UNDER)
                    begin
                        if (run_len < offset_t'(KEYWORD_CHARS))
                            window[run_len[2:0]] = upper(c);
                        run_len = sat_step(run_len);
                        taken = 1'b1;
                    end
                end
                MODE_NUMBER:
                begin
                    if (digit(c))
                    begin
                        run_len = sat_step(run_len);
                        taken = 1'b1;
                    end
                end
                MODE_STRING:
                begin
                    if (c == (dq_open ? CHAR_DQUOTE : CHAR_SQUOTE))
                    begin
                        mode = MODE_IDLE;
                        note_token(KIND_STRING, run_start, run_len, 1'b1);
                        taken = 1'b1;
                    end
                    else if (c != CHAR_NUL)
                    begin
                        run_len = sat_step(run_len);
                        taken = 1'b1;
                    end
                end
                MODE_LT, MODE_GT, MODE_BANG:
                begin
                    if (c == CHAR_EQ)
                    begin
                        note_token((mode == MODE_LT) ? KIND_LTE :
                                   (mode == MODE_GT) ? KIND_GTE : KIND_NEQ,
                                   run_start, offset_t'(2), 1'b0);
                        mode = MODE_IDLE;
                        taken = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!taken)
            begin
                flush_run();
                start_fresh(c, here);
            end
        end
        if (step_out.size() != 0)
            step_out[step_out.size() - 1].last_of_run = 1'b1;
        foreach (step_out[i])
            tokens_due.insert(tokens_due.size(), step_out[i]);
    endtask

    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= REPORT_LINES)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_token();
        token_t want;
        if (tokens_due.size() == 0)
        begin
            report_mismatch($sformatf("token kind %0d start %0d arrived with none pending",
                                      tok_ch.token_kind, tok_ch.token_start));
            return;
        end
        want = tokens_due.pop_front();
        if (tok_ch.token_kind != want.token_kind)
            report_mismatch($sformatf("token_kind got %0d, expected %0d",
                                      tok_ch.token_kind, want.token_kind));
        if (tok_ch.token_start != want.token_start)
            report_mismatch($sformatf("token_start got %0d, expected %0d",
                                      tok_ch.token_start, want.token_start));
        if (tok_ch.token_length != want.token_length)
            report_mismatch($sformatf("token_length got %0d, expected %0d",
                                      tok_ch.token_length, want.token_length));
        if (tok_ch.string_closed != want.string_closed)
            report_mismatch($sformatf("string_closed got %0d, expected %0d",
                                      tok_ch.string_closed, want.string_closed));
        if (tok_ch.last_of_run != want.last_of_run)
            report_mismatch($sformatf("last_of_run got %0d, expected %0d",
                                      tok_ch.last_of_run, want.last_of_run));
    endtask

    task automatic put_byte(logic [7:0] c);
        text_queue.insert(text_queue.size(), text_item_t'{action: 1'b0, char_byte: c});
        items_pushed++;
    endtask

    task automatic put_end();
        text_queue.insert(text_queue.size(),
                          text_item_t'{action: 1'b1, char_byte: 8'($urandom_range(255))});
        items_pushed++;
    endtask

    task automatic put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put_byte(s[i]);
    endtask

    function automatic logic [7:0] any_letter();
        return 8'h41 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
    endfunction

    function automatic logic [7:0] any_word_char();
        int r;
        r = $urandom_range(62);
        if (r < 52)
            return any_letter();
        if (r < 62)
            return 8'h30 + 8'($urandom_range(9));
        return CHAR_UNDER;
    endfunction

    task automatic put_keyword(string w);
        logic [7:0] c;
        for (int i = 0; i < w.len(); i++)
        begin
            c = w[i];
            put_byte($urandom_range(1) ? c | 8'h20 : c);
        end
    endtask

    task automatic add_word();
        int         pick;
        int         count;
        logic [7:0] q;
        logic [7:0] c;
        pick = $urandom_range(99);
        if (pick < 22)
            put_keyword(kw_words[$urandom_range(KW_COUNT - 1)]);
        else if (pick < 40)
        begin
            if ($urandom_range(3) == 0)
            begin
                put_keyword(kw_words[$urandom_range(KW_COUNT - 1)]);
                put_byte(any_word_char());
            end
            else
            begin
                put_byte(any_letter());
                count = $urandom_range(9);
                repeat (count)
                    put_byte(any_word_char());
            end
        end
        else if (pick < 52)
        begin
            count = $urandom_range(1, 6);
            repeat (count)
                put_byte(8'h30 + 8'($urandom_range(9)));
        end
        else if (pick < 66)
        begin
            q = $urandom_range(1) ? CHAR_DQUOTE : CHAR_SQUOTE;
            put_byte(q);
            count = $urandom_range(8);
            repeat (count)
            begin
                c = 8'($urandom_range(32, 255));
                put_byte(c == q ? 8'h2E : c);
            end
            pick = $urandom_range(19);
            if (pick < 17)
                put_byte(q);
            else if (pick < 19)
                put_byte(CHAR_NUL);
        end
        else if (pick < 90)
            put_text(sym_words[$urandom_range(11)]);
        else
        begin
            case ($urandom_range(5))
                0: put_byte(CHAR_UNDER);
                1: put_byte(CHAR_BANG);
                2: put_byte(CHAR_NUL);
                3: put_byte(8'($urandom_range(1, 8)));
                4: put_byte(8'($urandom_range(14, 31)));
                default: put_byte(8'($urandom_range(127, 255)));
            endcase
        end
    endtask

    task automatic add_gap();
        int count;
        if ($urandom_range(9) < 3)
            return;
        count = $urandom_range(1, 3);
        repeat (count)
            put_byte($urandom_range(3) ? 8'h20 : 8'($urandom_range(9, 13)));
    endtask

    task automatic add_statement();
        int count;
        if ($urandom_range(99) < 12)
        begin
            count = $urandom_range(1, 6);
            repeat (count)
                put_byte(8'($urandom_range(255)));
            if ($urandom_range(1))
                put_end();
            return;
        end
        count = $urandom_range(1, 8);
        repeat (count)
        begin
            add_word();
            add_gap();
        end
        if ($urandom_range(99) < 85)
            put_end();
    endtask

    task automatic wait_taken();
        while (items_taken != items_pushed)
            @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        mode = MODE_IDLE;
        dq_open = 1'b0;
        scan_pos = '0;
        run_start = '0;
        run_len = '0;
        window = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        put_end();
        put_text("'ab");
        put_byte(CHAR_NUL);
        put_text("<x>1!_");
        put_byte(8'hFF);
        put_text("\"q");
        put_end();
        put_text("VarChar(");
        while (items_pushed < 320)
            add_statement();
        wait_taken();

        send_gap_pct = 82;
        recv_gap_pct = 36;
        while (items_pushed < 640)
            add_statement();
        wait_taken();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        while (items_pushed < 940)
            add_statement();
        wait_taken();

        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ch.valid <= 1'b0;
            text_ch.action <= 1'b0;
            text_ch.char_byte <= 8'h00;
            tok_ch.ready <= 1'b0;
        end
        else
        begin
            if (!text_ch.valid || text_ch.ready)
            begin
                if (text_queue.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    item_now = text_queue.pop_front();
                    text_ch.valid <= 1'b1;
                    text_ch.action <= item_now.action;
                    text_ch.char_byte <= item_now.char_byte;
                end
                else
                    text_ch.valid <= 1'b0;
            end
            tok_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycles++;
            if (text_ch.valid && text_ch.ready)
            begin
                scan_item(text_ch.action, text_ch.char_byte);
                items_taken++;
            end
            if (tok_ch.valid && tok_ch.ready)
                check_token();
            if (cycles > CYCLE_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

// File: files.f
sv/sts_pkg.sv
sv/sts_channels.sv
sv/sql_token_scanner.sv
sv/sts_checker.sv
tb/tb_sql_token_scanner.sv
